// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that ante implies cons at the same rising edge of clk.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== src/kss_pkg.sv =====
// Package of types, constants and helpers for the k-sorted stream sorter.
`default_nettype none

package kss_pkg;

	localparam int DATA_W      = 32;
	localparam int MAX_REACH   = 15;
	localparam int DEPTH       = MAX_REACH + 1;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int REACH_W     = 4;
	localparam logic [REACH_W-1:0] REACH_RESET = REACH_W'(2);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_PICK = 4'b1000
	} state_t;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Two's complement less-than.
	function automatic logic val_less(input data_t a, input data_t b);
		return $signed(a) < $signed(b);
	endfunction

endpackage

`default_nettype wire

// ===== src/kss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/kss_min_scan.sv =====
// Running minimum over the entries read back from the store during a scan.
`default_nettype none

module kss_min_scan (
	input  wire logic          clk,
	input  wire logic          rd_s1,
	input  wire kss_pkg::addr_t idx_s1,
	input  wire kss_pkg::data_t rd_data,
	output kss_pkg::data_t     best_val_q,
	output kss_pkg::addr_t     best_idx_q,
	output kss_pkg::data_t     last_val_q
);

	// Restart on entry zero; keep the first of equal minima.
	always_ff @(posedge clk) begin
		if (rd_s1) begin
			last_val_q <= rd_data;
			if ((idx_s1 == '0) || kss_pkg::val_less(rd_data, best_val_q)) begin
				best_val_q <= rd_data;
				best_idx_q <= idx_s1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/k_sorted_stream_sorter_top.sv =====
// Top level of the k-sorted stream sorter: control sequencer, store and output register.
`default_nettype none
`include "assert_macros.svh"

// Usage:
//   s_axis carries the nearly sorted stream: tdata is the value, tlast ends the
//   stream and starts the flush. m_axis carries results in ascending order:
//   tdata is the value, tlast marks the last result caused by one input
//   transaction, tuser[0] marks the final result of the whole stream.
//   cfg_we/cfg_wdata set window_reach (reset 2); write it only while idle.
// Timing:
//   An input transaction is taken while the sequencer is idle. If it causes
//   no result the block is ready again on the next cycle. Each result needs
//   one read sweep of the store (one read per cycle through the single RAM
//   read port), a wait step for the last read data, and a pick step that
//   loads the output register and writes back. A flush sweeps the store once
//   for every held value.
// Reset:
//   arst_n empties the store (count to zero) and drops the output valid;
//   the RAM contents are not cleared and need no clearing pass.
// Stalls:
//   A result waits in the output register; the sequencer holds in its pick
//   step until the register is free, and input is not taken meanwhile.

module k_sorted_stream_sorter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_axis_tdata: [31:0] value
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,
	// m_axis_tdata: [31:0] sorted_value; m_axis_tuser: [0] stream_done
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	output logic [0:0]       m_axis_tuser,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata
);

	kss_pkg::state_t                 state_q;
	kss_pkg::cnt_t                   held_count_q;
	logic [kss_pkg::REACH_W-1:0]     reach_q;
	logic                            flush_q;
	kss_pkg::addr_t                  rd_idx_q;
	logic                            rd_s1;
	kss_pkg::addr_t                  idx_s1;
	logic                            out_valid_q;
	kss_pkg::data_t                  out_data_q;
	logic                            out_last_q;
	logic                            out_done_q;

	kss_pkg::data_t                  rd_data;
	kss_pkg::data_t                  best_val_q;
	kss_pkg::addr_t                  best_idx_q;
	kss_pkg::data_t                  last_val_q;

	logic                            in_fire;
	logic                            out_free;
	logic                            pick_fire;
	logic                            ram_we;
	kss_pkg::addr_t                  ram_waddr;
	kss_pkg::data_t                  ram_wdata;
	logic                            ram_re;
	kss_pkg::cnt_t                   cnt_inc;
	kss_pkg::cnt_t                   cnt_dec;
	logic                            scan_end;
	logic                            fin;

	assign s_axis_tready = (state_q == kss_pkg::ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign pick_fire     = (state_q == kss_pkg::ST_PICK) && out_free;

	assign cnt_inc  = held_count_q + kss_pkg::CNT_W'(1);
	assign cnt_dec  = held_count_q - kss_pkg::CNT_W'(1);
	// Last entry of the sweep is the one at count minus one.
	assign scan_end = (rd_idx_q == cnt_dec[kss_pkg::ADDR_W-1:0]);
	assign fin      = (cnt_dec == '0);

	// Insert at the tail on input; fill the hole left by the minimum with the
	// tail entry on pick. Order within the store does not matter.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = held_count_q[kss_pkg::ADDR_W-1:0];
		ram_wdata = s_axis_tdata;
		if (in_fire) begin
			ram_we = 1'b1;
		end else if (pick_fire) begin
			ram_we    = 1'b1;
			ram_waddr = best_idx_q;
			ram_wdata = last_val_q;
		end
	end

	assign ram_re = (state_q == kss_pkg::ST_SCAN);

	kss_ram #(
		.WIDTH(kss_pkg::DATA_W),
		.DEPTH(kss_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_idx_q),
		.rdata(rd_data)
	);

	kss_min_scan u_min (
		.clk       (clk),
		.rd_s1     (rd_s1),
		.idx_s1    (idx_s1),
		.rd_data   (rd_data),
		.best_val_q(best_val_q),
		.best_idx_q(best_idx_q),
		.last_val_q(last_val_q)
	);

	// Sequencer: take an item, sweep the store, emit the minimum; repeat until empty during a flush.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kss_pkg::ST_IDLE;
			held_count_q <= '0;
			flush_q      <= 1'b0;
			rd_idx_q     <= '0;
			rd_s1        <= 1'b0;
		end else begin
			rd_s1 <= (state_q == kss_pkg::ST_SCAN);
			unique case (state_q)
				kss_pkg::ST_IDLE: begin
					if (in_fire) begin
						held_count_q <= cnt_inc;
						flush_q      <= s_axis_tlast;
						rd_idx_q     <= '0;
						// Emit once the count exceeds the reach, or on the last item.
						if (s_axis_tlast ||
						    (cnt_inc > kss_pkg::CNT_W'(reach_q))) begin
							state_q <= kss_pkg::ST_SCAN;
						end
					end
				end
				kss_pkg::ST_SCAN: begin
					if (scan_end) begin
						state_q <= kss_pkg::ST_WAIT;
					end else begin
						rd_idx_q <= rd_idx_q + kss_pkg::ADDR_W'(1);
					end
				end
				kss_pkg::ST_WAIT: begin
					state_q <= kss_pkg::ST_PICK;
				end
				kss_pkg::ST_PICK: begin
					if (out_free) begin
						held_count_q <= cnt_dec;
						rd_idx_q     <= '0;
						if (flush_q && !fin) begin
							state_q <= kss_pkg::ST_SCAN;
						end else begin
							state_q <= kss_pkg::ST_IDLE;
							flush_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= kss_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= kss_pkg::REACH_RESET;
		end else if (cfg_we) begin
			reach_q <= cfg_wdata;
		end
	end

	// Output register: hold until taken, load on pick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pick_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pick_fire) begin
			out_data_q <= best_val_q;
			out_last_q <= !flush_q || fin;
			out_done_q <= flush_q && fin;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tlast    = out_last_q;
	assign m_axis_tuser[0] = out_done_q;

	`ASSERT_CLK(a_count_range, held_count_q <= kss_pkg::CNT_W'(kss_pkg::DEPTH),
		"held count above store depth")
	`ASSERT_IMPL(a_pick_nonempty, state_q == kss_pkg::ST_PICK, held_count_q != '0,
		"pick with empty store")
	`ASSERT_IMPL(a_done_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast,
		"stream done without run last")
	`ASSERT_CLK(a_no_overwrite, !(pick_fire && out_valid_q && !m_axis_tready),
		"output register overwritten while stalled")

endmodule

`default_nettype wire
